// File: src/sva_pkg.sv
package sva_pkg;

  // Default sizes of the store
  localparam int NumElementsDef = 1024;
  localparam int VersionsDef    = 16;
  localparam int SnapBitsDef    = 16;

  // Fixed field widths
  localparam int ModeW   = 2;
  localparam int IdxW    = 10;
  localparam int ValW    = 32;
  localparam int QueryW  = 16;
  localparam int SnapOutW = 16;
  localparam int LenW    = 11;
  localparam int StatusW = 2;

  localparam logic [LenW-1:0] LEN_RESET = 11'd1024;

  // Operation codes
  localparam logic [ModeW-1:0] MODE_SET  = 2'd0;
  localparam logic [ModeW-1:0] MODE_SNAP = 2'd1;
  localparam logic [ModeW-1:0] MODE_GET  = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_RANGE = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;
  localparam logic [StatusW-1:0] STATUS_SAT   = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_TOP,
    S_SETCHK,
    S_SRCH,
    S_PROBE,
    S_FETCH,
    S_DONE
  } state_t;

  // Version memory read address source
  typedef enum logic [1:0] {
    RD_TOP,
    RD_MID,
    RD_LO
  } rd_sel_t;

  typedef struct packed {
    logic                clr_en;
    logic                accept;
    logic                cnt_rd;
    logic                ver_rd;
    rd_sel_t             rd_sel;
    logic                srch_init;
    logic                probe_upd;
    logic                snap_take;
    logic                ver_over;
    logic                ver_app;
    logic                fetch_take;
    logic                status_we;
    logic [StatusW-1:0]  status_code;
    logic                out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic              clr_last;
    logic [ModeW-1:0]  mode;
    logic              idx_ok;
    logic              snap_sat;
    logic              top_match;
    logic              list_full;
    logic              lo_eq_hi;
    logic              probe_le;
    logic              out_free;
  } dp_stat_t;

endpackage

// File: src/sva_ctrl.sv
module sva_ctrl import sva_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if ((stat.mode == MODE_SET || stat.mode == MODE_GET) && stat.idx_ok) begin
          state_next = S_TOP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TOP: begin
        if (stat.mode == MODE_SET) state_next = S_SETCHK;
        else state_next = S_SRCH;
      end
      S_SETCHK: state_next = S_DONE;
      S_SRCH: begin
        if (stat.lo_eq_hi) state_next = S_FETCH;
        else state_next = S_PROBE;
      end
      S_PROBE: state_next = S_SRCH;
      S_FETCH: state_next = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_TOP;
    cmd.status_code = STATUS_OK;
    req_stall = 1'b1;
    case (state)
      S_CLEAR: cmd.clr_en = 1'b1;
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.accept = req_valid;
      end
      S_DISPATCH: begin
        cmd.cnt_rd = 1'b1;
        if (stat.mode == MODE_SNAP) begin
          if (stat.snap_sat) begin
            cmd.status_we = 1'b1;
            cmd.status_code = STATUS_SAT;
          end else begin
            cmd.snap_take = 1'b1;
          end
        end else if ((stat.mode == MODE_SET || stat.mode == MODE_GET) && !stat.idx_ok) begin
          cmd.status_we = 1'b1;
          cmd.status_code = STATUS_RANGE;
        end
      end
      S_TOP: begin
        if (stat.mode == MODE_SET) begin
          cmd.ver_rd = 1'b1;
          cmd.rd_sel = RD_TOP;
        end else begin
          cmd.srch_init = 1'b1;
        end
      end
      S_SETCHK: begin
        if (stat.top_match) begin
          cmd.ver_over = 1'b1;
        end else if (stat.list_full) begin
          cmd.status_we = 1'b1;
          cmd.status_code = STATUS_FULL;
        end else begin
          cmd.ver_app = 1'b1;
        end
      end
      S_SRCH: begin
        cmd.ver_rd = 1'b1;
        cmd.rd_sel = stat.lo_eq_hi ? RD_LO : RD_MID;
      end
      S_PROBE: cmd.probe_upd = 1'b1;
      S_FETCH: cmd.fetch_take = 1'b1;
      S_DONE: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: src/sva_datapath.sv
module sva_datapath import sva_pkg::*; #(
  parameter int NUM_ELEMENTS         = NumElementsDef,
  parameter int VERSIONS_PER_ELEMENT = VersionsDef,
  parameter int SNAP_BITS            = SnapBitsDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [LenW-1:0]           cfg_wr_data,
  input  logic [ModeW-1:0]          mode,
  input  logic [IdxW-1:0]           element_index,
  input  logic signed [ValW-1:0]    write_value,
  input  logic [QueryW-1:0]         query_snap,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic signed [ValW-1:0]    read_value,
  output logic [SnapOutW-1:0]       snap_number,
  output logic [StatusW-1:0]        status,
  input  ctl_cmd_t                  cmd,
  output dp_stat_t                  stat
);

  localparam int EW    = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int SW    = $clog2(VERSIONS_PER_ELEMENT);
  localparam int CW    = $clog2(VERSIONS_PER_ELEMENT + 1);
  localparam int AW    = EW + SW;
  localparam int VDEPTH = NUM_ELEMENTS * (1 << SW);
  localparam int VW    = SNAP_BITS + ValW;

  logic [LenW-1:0]        array_length;
  logic [SNAP_BITS-1:0]   snap_counter;

  logic [ModeW-1:0]       req_mode;
  logic [IdxW-1:0]        req_idx;
  logic [ValW-1:0]        req_wval;
  logic [QueryW-1:0]      req_query;

  logic [EW-1:0]          clr_ptr;
  logic [CW-1:0]          cnt_q;
  logic [VW-1:0]          ver_q;
  logic [SW-1:0]          lo;
  logic [SW-1:0]          hi;

  logic [ValW-1:0]        res_value;
  logic [SnapOutW-1:0]    res_snap;
  logic [StatusW-1:0]     res_status;

  logic [CW-1:0]          cnt_mem [NUM_ELEMENTS];
  logic [VW-1:0]          ver_mem [VDEPTH];

  logic [16:0]            idx_ext;
  logic [EW-1:0]          elem;
  logic [CW-1:0]          cnt_dec;
  logic [CW-1:0]          cnt_inc;
  logic [SW-1:0]          top_slot;
  logic [SW:0]            span;
  logic [SW:0]            mid_w;
  logic [SW-1:0]          mid;
  logic [SW-1:0]          rd_slot;
  logic [SNAP_BITS-1:0]   ver_q_snap;
  logic [31:0]            counter_ext;
  logic [VW-1:0]          new_entry;

  // Decode the held request
  always_comb begin
    idx_ext     = {7'b0, req_idx};
    elem        = idx_ext[EW-1:0];
    cnt_dec     = cnt_q - CW'(1);
    cnt_inc     = cnt_q + CW'(1);
    top_slot    = cnt_dec[SW-1:0];
    span        = {1'b0, hi} - {1'b0, lo} + (SW+1)'(1);
    mid_w       = {1'b0, lo} + {1'b0, span[SW:1]};
    mid         = mid_w[SW-1:0];
    ver_q_snap  = ver_q[VW-1:ValW];
    counter_ext = 32'(snap_counter);
    new_entry   = {snap_counter, req_wval};
    case (cmd.rd_sel)
      RD_TOP:  rd_slot = top_slot;
      RD_MID:  rd_slot = mid;
      RD_LO:   rd_slot = lo;
      default: rd_slot = lo;
    endcase
  end

  // Report status to the controller
  always_comb begin
    stat.clr_last  = (clr_ptr == EW'(NUM_ELEMENTS - 1));
    stat.mode      = req_mode;
    stat.idx_ok    = ({1'b0, req_idx} < array_length) && (idx_ext < 17'(NUM_ELEMENTS));
    stat.snap_sat  = &snap_counter;
    stat.top_match = (ver_q_snap == snap_counter);
    stat.list_full = (cnt_q >= CW'(VERSIONS_PER_ELEMENT));
    stat.lo_eq_hi  = (lo == hi);
    stat.probe_le  = (32'(ver_q_snap) <= 32'(req_query));
    stat.out_free  = !rsp_valid || !rsp_stall;
  end

  // Configuration, counter and clear pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      array_length <= LEN_RESET;
      snap_counter <= '0;
      clr_ptr      <= '0;
    end else begin
      if (cfg_wr_en) array_length <= cfg_wr_data;
      if (cmd.snap_take) snap_counter <= snap_counter + SNAP_BITS'(1);
      if (cmd.clr_en) clr_ptr <= clr_ptr + EW'(1);
    end
  end

  // Latch the request and the search bounds
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode  <= mode;
      req_idx   <= element_index;
      req_wval  <= write_value;
      req_query <= query_snap;
    end
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= top_slot;
    end else if (cmd.probe_upd) begin
      if (stat.probe_le) lo <= mid;
      else hi <= mid - SW'(1);
    end
  end

  // Version count memory
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      cnt_mem[clr_ptr] <= CW'(1);
    end else if (cmd.ver_app) begin
      cnt_mem[elem] <= cnt_inc;
    end
    if (cmd.cnt_rd) cnt_q <= cnt_mem[elem];
  end

  // Version memory: snapshot id over value
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      ver_mem[{clr_ptr, SW'(0)}] <= '0;
    end else if (cmd.ver_over) begin
      ver_mem[{elem, top_slot}] <= new_entry;
    end else if (cmd.ver_app) begin
      ver_mem[{elem, cnt_q[SW-1:0]}] <= new_entry;
    end
    if (cmd.ver_rd) ver_q <= ver_mem[AW'({elem, rd_slot})];
  end

  // Build the result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_value  <= '0;
      res_snap   <= '0;
      res_status <= STATUS_OK;
    end else begin
      if (cmd.status_we) res_status <= cmd.status_code;
      if (cmd.snap_take) res_snap <= counter_ext[SnapOutW-1:0];
      if (cmd.fetch_take) res_value <= ver_q[ValW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_value  <= res_value;
      snap_number <= res_snap;
      status      <= res_status;
    end
  end

endmodule

// File: src/snapshot_versioned_array_core.sv
// Channel    | Handshake              | Payload
// request    | req_valid / req_stall  | mode, element_index, write_value, query_snap
// response   | rsp_valid / rsp_stall  | read_value, snap_number, status
// config     | cfg_wr_en              | cfg_wr_data (array length)
//
// One request at a time. From acceptance to the response register: snap, unused mode and
// index out of range pass DISPATCH and DONE; set passes DISPATCH, TOP, SETCHK and DONE;
// get passes DISPATCH, TOP, a binary search of SRCH and PROBE steps with one registered
// memory read per step, then FETCH and DONE; IDLE then takes the next request.
// After reset a clearing pass over all NUM_ELEMENTS elements (1024 by default) sets each
// element to one version of value 0 at snapshot 0; req_stall stays high meanwhile.
// A new request is taken while a finished response waits under rsp_stall.
module snapshot_versioned_array_core import sva_pkg::*; #(
  parameter int NUM_ELEMENTS         = NumElementsDef,
  parameter int VERSIONS_PER_ELEMENT = VersionsDef,
  parameter int SNAP_BITS            = SnapBitsDef
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [LenW-1:0]          cfg_wr_data,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [ModeW-1:0]         mode,
  input  logic [IdxW-1:0]          element_index,
  input  logic signed [ValW-1:0]   write_value,
  input  logic [QueryW-1:0]        query_snap,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [ValW-1:0]   read_value,
  output logic [SnapOutW-1:0]      snap_number,
  output logic [StatusW-1:0]       status
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  sva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sva_datapath #(
    .NUM_ELEMENTS         (NUM_ELEMENTS),
    .VERSIONS_PER_ELEMENT (VERSIONS_PER_ELEMENT),
    .SNAP_BITS            (SNAP_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mode          (mode),
    .element_index (element_index),
    .write_value   (write_value),
    .query_snap    (query_snap),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .read_value    (read_value),
    .snap_number   (snap_number),
    .status        (status),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
